[sv/era_pkg.sv]
// Package with constants, coefficients and the shared side-data type for the exponential unit.
`timescale 1ns / 1ps

package era_pkg;

  localparam int ARG_FRAC_BITS  = 16;
  localparam int MANT_FRAC_BITS = 30;

  localparam int ARG_W  = 27;
  localparam int HIGH_W = 26;
  localparam int MANT_W = 32;
  localparam int EXP_W  = 12;
  localparam int N_W    = 13;

  localparam int T_SHIFT = ARG_FRAC_BITS + 32;
  localparam int F_SHIFT = 60 - T_SHIFT;
  localparam logic [63:0] T_MASK = (64'd1 << T_SHIFT) - 64'd1;

  localparam int RND_SHIFT = 60 - MANT_FRAC_BITS;
  localparam logic [63:0] RND_ADD = 64'd1 << (RND_SHIFT - 1);

  localparam int DIV_STEPS = 63;

  localparam logic [63:0] INV_LN2_Q32 = 64'h0000_0001_7154_7653;
  localparam logic [63:0] SQRT2_Q60   = 64'h16A0_9E66_7F3B_CC91;
  localparam logic [63:0] ONE_Q60     = 64'd1 << 60;
  localparam logic [63:0] HALF_Q60    = 64'd1 << 59;

  localparam logic [63:0] COEF_P0 = 64'd208038434669466300;
  localparam logic [63:0] COEF_P1 = 64'd3028697169744036;
  localparam logic [63:0] COEF_P2 = 64'd6061485330061;
  localparam logic [63:0] COEF_Q0 = 64'd600272036023883253;
  localparam logic [63:0] COEF_Q1 = 64'd32772515180829144;
  localparam logic [63:0] COEF_Q2 = 64'd174928768909308;
  localparam logic [63:0] COEF_Q3 = 64'd100000000000;

  localparam logic [N_W-1:0] N_CAP = 13'd4096;
  localparam logic [N_W-1:0] N_SAT = 13'd2047;

  localparam logic [63:0] MIN_M64 = 64'd1 << MANT_FRAC_BITS;
  localparam logic [63:0] MAX_M64 = (64'd2 << MANT_FRAC_BITS) - 64'd1;
  localparam logic [MANT_W-1:0] MANT_MIN =
    (MIN_M64 > 64'hFFFF_FFFF) ? '1 : MIN_M64[MANT_W-1:0];
  localparam logic [MANT_W-1:0] MANT_MAX =
    (MAX_M64 > 64'hFFFF_FFFF) ? '1 : MAX_M64[MANT_W-1:0];
  localparam logic signed [EXP_W-1:0] EXP_MIN = -12'sd1022;
  localparam logic signed [EXP_W-1:0] EXP_MAX = 12'sd1023;

  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_MIN    = 2'd1;
  localparam logic [1:0] STATUS_MAX    = 2'd2;

  localparam logic REG_LOW_LIMIT  = 1'b0;
  localparam logic REG_HIGH_LIMIT = 1'b1;

  localparam logic signed [ARG_W-1:0] LOW_LIMIT_RST  = -27'sd46425468;
  localparam logic [HIGH_W-1:0]       HIGH_LIMIT_RST = 26'd46516320;

  typedef struct packed {
    logic [1:0]     status;
    logic           range_error;
    logic           neg;
    logic           over_half;
    logic [N_W-1:0] n;
    logic [63:0]    f;
    logic [63:0]    z;
  } era_side_t;

endpackage

[sv/era_mac.sv]
// Two-stage multiply-add: c + bits [123:60] of a 64 by 64 product, side data alongside.
`timescale 1ns / 1ps

module era_mac import era_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  input  era_side_t   side_in,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  output logic        valid_out,
  output era_side_t   side_out,
  output logic [63:0] p
);

  logic        valid1;
  era_side_t   side1;
  logic [63:0] ll, lh, hl, hh, c1;
  logic [127:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid1 <= valid_in;
      valid_out <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    ll <= 64'(a[31:0]) * 64'(b[31:0]);
    lh <= 64'(a[31:0]) * 64'(b[63:32]);
    hl <= 64'(a[63:32]) * 64'(b[31:0]);
    hh <= 64'(a[63:32]) * 64'(b[63:32]);
    c1 <= c;
    side1 <= side_in;
  end

  assign prod = {64'd0, ll} + ({64'd0, lh} << 32) + ({64'd0, hl} << 32) + {hh, 64'd0};

  always_ff @(posedge clk) begin
    p <= c1 + prod[123:60];
    side_out <= side1;
  end

endmodule

[sv/era_div.sv]
// Pipelined restoring divider giving num / den as an unsigned Q60 quotient, one bit per stage.
`timescale 1ns / 1ps

module era_div import era_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  input  era_side_t   side_in,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        valid_out,
  output era_side_t   side_out,
  output logic [63:0] quot
);

  logic [63:0] rem_q [DIV_STEPS];
  logic [62:0] quo_q [DIV_STEPS];
  logic [63:0] den_q [DIV_STEPS];
  logic [2:0]  nlo_q [DIV_STEPS];
  era_side_t   sd_q  [DIV_STEPS];
  logic        vl_q  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0] rem_c, den_c;
    logic [62:0] quo_c;
    logic [2:0]  nlo_c;
    era_side_t   sd_c;
    logic        vl_c;
    logic [64:0] rs, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_c = num >> 3;
      assign quo_c = '0;
      assign den_c = den;
      assign nlo_c = num[2:0];
      assign sd_c  = side_in;
      assign vl_c  = valid_in;
    end else begin : g_next
      assign rem_c = rem_q[k-1];
      assign quo_c = quo_q[k-1];
      assign den_c = den_q[k-1];
      assign nlo_c = nlo_q[k-1];
      assign sd_c  = sd_q[k-1];
      assign vl_c  = vl_q[k-1];
    end

    assign rs   = {rem_c, nlo_c[2]};
    assign diff = rs - {1'b0, den_c};
    assign ge   = rs >= {1'b0, den_c};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl_q[k] <= 1'b0;
      end else begin
        vl_q[k] <= vl_c;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= ge ? diff[63:0] : rs[63:0];
      quo_q[k] <= {quo_c[61:0], ge};
      den_q[k] <= den_c;
      nlo_q[k] <= {nlo_c[1:0], 1'b0};
      sd_q[k]  <= sd_c;
    end
  end

  assign quot      = {1'b0, quo_q[DIV_STEPS-1]};
  assign side_out  = sd_q[DIV_STEPS-1];
  assign valid_out = vl_q[DIV_STEPS-1];

endmodule

[sv/exp_rational_approx.sv]
// Top level of the pipelined e^x unit with mantissa and power-of-two exponent.
// Throughput: one argument per cycle; two 63-stage dividers set the depth.
// busy is high only during reset, so start is taken in every cycle.
// Synchronous reset clears all valid bits and loads the default limits.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module exp_rational_approx import era_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ARG_W-1:0]  argument,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [ARG_W-1:0]         cfg_data,
  output logic                     done,
  output logic [MANT_W-1:0]        mantissa,
  output logic signed [EXP_W-1:0]  exponent,
  output logic [1:0]               status,
  output logic                     range_error
);

  logic signed [ARG_W-1:0] low_limit;
  logic [HIGH_W-1:0]       high_limit;
  logic                    accept;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RST;
      high_limit <= HIGH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOW_LIMIT:  low_limit  <= cfg_data;
        REG_HIGH_LIMIT: high_limit <= cfg_data[HIGH_W-1:0];
      endcase
    end
  end

  // Stage 1: limit checks and magnitude.
  logic signed [ARG_W-1:0] high_s;
  era_side_t side0, side1, side2, side3;
  logic [ARG_W-1:0] mag0, mag1;
  logic v1, v2, v3;

  assign high_s = $signed({1'b0, high_limit});

  always_comb begin
    side0 = '0;
    side0.neg = argument[ARG_W-1];
    priority if (argument <= low_limit) begin
      side0.status = STATUS_MIN;
      side0.range_error = argument < low_limit;
    end else if (argument >= high_s) begin
      side0.status = STATUS_MAX;
      side0.range_error = argument > high_s;
    end else begin
      side0.status = STATUS_NORMAL;
      side0.range_error = 1'b0;
    end
    mag0 = argument[ARG_W-1] ? ARG_W'(-argument) : argument;
  end

  // Stage 2: scale by 1/ln2. Stage 3: split into exponent and fraction.
  logic [63:0] t2, fr, f3;
  logic [63:0] nt;
  logic [N_W-1:0] n3;
  logic over_half3;
  era_side_t side3_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign nt = t2 >> T_SHIFT;
  assign fr = (t2 & T_MASK) << F_SHIFT;

  always_comb begin
    n3 = (nt > 64'(N_CAP)) ? N_CAP : nt[N_W-1:0];
    over_half3 = fr > HALF_Q60;
    f3 = over_half3 ? fr - HALF_Q60 : fr;
    side3_next = side2;
    side3_next.n = n3;
    side3_next.over_half = over_half3;
    side3_next.f = f3;
  end

  always_ff @(posedge clk) begin
    side1 <= side0;
    mag1  <= mag0;
    t2    <= 64'(mag1) * INV_LN2_Q32;
    side2 <= side1;
    side3 <= side3_next;
  end

  // Polynomial evaluation.
  era_side_t sm1, sz, sm2, sm3, sm4;
  logic vm1, vm2, vm3, vm4;
  logic [63:0] z1, pv1, qv2, pv, qv1, xp, qv;

  era_mac u_m1 (.clk, .rst, .valid_in(v3), .side_in(side3),
    .a(side3.f), .b(side3.f), .c(64'd0), .valid_out(vm1), .side_out(sm1), .p(z1));

  always_comb begin
    sz = sm1;
    sz.z = z1;
  end

  era_mac u_m2p (.clk, .rst, .valid_in(vm1), .side_in(sz),
    .a(COEF_P2), .b(sz.z), .c(COEF_P1), .valid_out(vm2), .side_out(sm2), .p(pv1));
  era_mac u_m2q (.clk, .rst, .valid_in(vm1), .side_in(sz),
    .a(COEF_Q3), .b(sz.z), .c(COEF_Q2), .valid_out(), .side_out(), .p(qv2));

  era_mac u_m3p (.clk, .rst, .valid_in(vm2), .side_in(sm2),
    .a(pv1), .b(sm2.z), .c(COEF_P0), .valid_out(vm3), .side_out(sm3), .p(pv));
  era_mac u_m3q (.clk, .rst, .valid_in(vm2), .side_in(sm2),
    .a(qv2), .b(sm2.z), .c(COEF_Q1), .valid_out(), .side_out(), .p(qv1));

  era_mac u_m4p (.clk, .rst, .valid_in(vm3), .side_in(sm3),
    .a(sm3.f), .b(pv), .c(64'd0), .valid_out(vm4), .side_out(sm4), .p(xp));
  era_mac u_m4q (.clk, .rst, .valid_in(vm3), .side_in(sm3),
    .a(qv1), .b(sm3.z), .c(COEF_Q0), .valid_out(), .side_out(), .p(qv));

  // Numerator and denominator of the rational form.
  logic [63:0] num5, den5;
  era_side_t side5;
  logic v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= vm4;
    end
  end

  always_ff @(posedge clk) begin
    num5  <= qv + xp;
    den5  <= qv - xp;
    side5 <= sm4;
  end

  // Quotient, optional sqrt2 step, then reciprocal for negative arguments.
  era_side_t sd1, ss, sq, sm, sd2;
  logic vd1, vq, vd2;
  logic [63:0] q1, ps, mv, q2;

  era_div u_div1 (.clk, .rst, .valid_in(v5), .side_in(side5),
    .num(num5), .den(den5), .valid_out(vd1), .side_out(sd1), .quot(q1));

  always_comb begin
    ss = sd1;
    ss.f = q1;
  end

  era_mac u_ms (.clk, .rst, .valid_in(vd1), .side_in(ss),
    .a(ss.f), .b(SQRT2_Q60), .c(64'd0), .valid_out(vq), .side_out(sq), .p(ps));

  always_comb begin
    mv = sq.over_half ? ps : sq.f;
    sm = sq;
    sm.f = mv;
  end

  era_div u_div2 (.clk, .rst, .valid_in(vq), .side_in(sm),
    .num(ONE_Q60), .den(mv), .valid_out(vd2), .side_out(sd2), .quot(q2));

  // Rounding, exponent and clamp selection.
  logic [63:0] mf, rsum, rsh;
  logic [MANT_W-1:0] mant_c;
  logic [EXP_W-1:0] nc;
  logic signed [EXP_W-1:0] exp_c;

  always_comb begin
    mf   = sd2.neg ? q2 : sd2.f;
    rsum = mf + RND_ADD;
    rsh  = rsum >> RND_SHIFT;
    mant_c = (rsh > 64'hFFFF_FFFF) ? '1 : rsh[MANT_W-1:0];
    nc = (sd2.n > N_SAT) ? EXP_W'(N_SAT) : sd2.n[EXP_W-1:0];
    exp_c = sd2.neg ? $signed(-nc) : $signed(nc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd2;
    end
  end

  always_ff @(posedge clk) begin
    status      <= sd2.status;
    range_error <= sd2.range_error;
    unique case (sd2.status)
      STATUS_MIN: begin
        mantissa <= MANT_MIN;
        exponent <= EXP_MIN;
      end
      STATUS_MAX: begin
        mantissa <= MANT_MAX;
        exponent <= EXP_MAX;
      end
      default: begin
        mantissa <= mant_c;
        exponent <= exp_c;
      end
    endcase
  end

endmodule

[sv/era_chk.sv]
// Port-level checker for the exponential unit and its bind to the top level.
`timescale 1ns / 1ps

module era_chk import era_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic signed [ARG_W-1:0] argument,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic                    cfg_index,
  input logic [ARG_W-1:0]        cfg_data,
  input logic                    done,
  input logic [MANT_W-1:0]       mantissa,
  input logic signed [EXP_W-1:0] exponent,
  input logic [1:0]              status,
  input logic                    range_error
);

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("Result strobe right after reset.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_NORMAL || status == STATUS_MIN || status == STATUS_MAX))
    else $error("Undefined status code on a result.");

  a_normal_no_error: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_NORMAL) |-> !range_error)
    else $error("Range error on an unclamped result.");

  a_min_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_MIN) |-> (mantissa == MANT_MIN && exponent == EXP_MIN))
    else $error("Minimum clamp transaction carries the wrong value.");

  a_max_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_MAX) |-> (mantissa == MANT_MAX && exponent == EXP_MAX))
    else $error("Maximum clamp transaction carries the wrong value.");

endmodule

bind exp_rational_approx era_chk u_era_chk (.*);

[sim/exp_rational_approx_tb.sv]
// Self-checking testbench for the exponential unit: random and directed arguments, with limit writes.
`timescale 1ns / 1ps

module exp_rational_approx_tb;
  import era_pkg::*;

  typedef struct {
    logic [MANT_W-1:0] mant;
    logic [EXP_W-1:0]  expo;
    logic [1:0]        stat;
    logic              rerr;
  } exp_result_t;

  typedef struct {
    logic              is_cfg;
    logic              idx;
    logic [ARG_W-1:0]  val;
    int                gap;
  } arg_job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [ARG_W-1:0] argument = '0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [ARG_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, range_error;
  logic [MANT_W-1:0] mantissa;
  logic signed [EXP_W-1:0] exponent;
  logic [1:0] status;

  exp_rational_approx u_top (
    .clk, .rst, .start, .busy, .argument, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .done, .mantissa, .exponent, .status, .range_error
  );

  initial forever #2 clk = ~clk;

  arg_job_t    pending_jobs[$];
  exp_result_t expected_results[$];
  longint      pred_low;
  longint      pred_high;
  int          errors = 0;
  int          args_sent = 0;
  int          results_seen = 0;
  int          clamp_count = 0;
  int          cfg_writes = 0;
  bit          stim_done = 0;
  int          wait_cnt = 0;
  int          quiet_cycles = 0;
  int          drain_cnt = 0;

  function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  function automatic logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return '1;
    q = {num, 60'd0} / den;
    return q[63:0];
  endfunction

  function automatic logic [EXP_W-1:0] sat_exp(longint e);
    if (e > 2047) e = 2047;
    if (e < -2047) e = -2047;
    return e[EXP_W-1:0];
  endfunction

  function automatic exp_result_t predict_exp(logic [ARG_W-1:0] raw);
    exp_result_t r;
    longint x;
    logic [63:0] a, t, f, z, pv, qv, xp, m, nn, rm;
    logic over_half;
    x = longint'($signed(raw));
    r.stat = STATUS_NORMAL;
    r.rerr = 1'b0;
    if (x <= pred_low) begin
      r.mant = MANT_MIN; r.expo = sat_exp(-1022); r.stat = STATUS_MIN;
      r.rerr = x < pred_low;
      return r;
    end
    if (x >= pred_high) begin
      r.mant = MANT_MAX; r.expo = sat_exp(1023); r.stat = STATUS_MAX;
      r.rerr = x > pred_high;
      return r;
    end
    a = (x < 0) ? -x : x;
    t = a * INV_LN2_Q32;
    nn = t >> T_SHIFT;
    f = (t & T_MASK) << F_SHIFT;
    over_half = f > HALF_Q60;
    if (over_half) f = f - HALF_Q60;
    z = mul_trunc(f, f);
    pv = COEF_P1 + mul_trunc(COEF_P2, z);
    pv = COEF_P0 + mul_trunc(pv, z);
    qv = COEF_Q2 + mul_trunc(COEF_Q3, z);
    qv = COEF_Q1 + mul_trunc(qv, z);
    qv = COEF_Q0 + mul_trunc(qv, z);
    xp = mul_trunc(f, pv);
    m = div_trunc(qv + xp, qv - xp);
    if (over_half) m = mul_trunc(m, SQRT2_Q60);
    if (nn > 4096) nn = 4096;
    if (x < 0) begin
      m = div_trunc(ONE_Q60, m);
      r.expo = sat_exp(-longint'(nn));
    end else begin
      r.expo = sat_exp(longint'(nn));
    end
    rm = (m + RND_ADD) >> RND_SHIFT;
    r.mant = (rm > 64'hFFFF_FFFF) ? '1 : rm[MANT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s at result %0d: got %0h want %0h", what, results_seen, got, want);
  endtask

  task automatic queue_arg(logic [ARG_W-1:0] v, int gap);
    pending_jobs.push_back('{1'b0, 1'b0, v, gap});
  endtask

  task automatic queue_cfg(logic idx, logic [ARG_W-1:0] v);
    pending_jobs.push_back('{1'b1, idx, v, 0});
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [ARG_W-1:0] rand_arg();
    unique case ($urandom_range(0, 4))
      0: return ARG_W'($urandom());
      1: return ARG_W'($urandom_range(0, 2 * 65536) - 65536);
      2: return ARG_W'($urandom_range(0, 20 * 65536) - 10 * 65536);
      3: return ARG_W'($urandom_range(0, 1400 * 65536) - 700 * 65536);
      default: return ARG_W'(longint'($urandom_range(0, 400)) - 200 +
                             (($urandom_range(0, 1) == 1) ? pred_low : pred_high));
    endcase
  endfunction

  // Driver: walks the job queue; config writes wait for the pipeline to drain.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      logic start_nxt, cfg_nxt;
      start_nxt = start;
      cfg_nxt = cfg_valid;
      if (start && !busy) begin
        args_sent++;
        start_nxt = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        cfg_nxt = 1'b0;
        if (cfg_index == REG_LOW_LIMIT) pred_low = longint'($signed(cfg_data));
        else pred_high = longint'(cfg_data[HIGH_W-1:0]);
      end
      if (!start_nxt && !cfg_nxt && pending_jobs.size() > 0) begin
        if (pending_jobs[0].is_cfg) begin
          if (expected_results.size() == 0 && !(start && !busy)) begin
            if (drain_cnt < 150) drain_cnt++;
            else begin
              drain_cnt = 0;
              cfg_nxt = 1'b1;
              cfg_index <= pending_jobs[0].idx;
              cfg_data <= pending_jobs[0].val;
              void'(pending_jobs.pop_front());
            end
          end
        end else if (wait_cnt < pending_jobs[0].gap) begin
          wait_cnt++;
        end else begin
          wait_cnt = 0;
          start_nxt = 1'b1;
          argument <= pending_jobs[0].val;
          expected_results.push_back(predict_exp(pending_jobs[0].val));
          void'(pending_jobs.pop_front());
        end
      end
      if (start && !busy && expected_results.size() == 0) begin
      end
      start <= start_nxt;
      cfg_valid <= cfg_nxt;
      if (!start_nxt && !cfg_nxt && pending_jobs.size() == 0) stim_done = 1;
    end
  end

  // Monitor: each done strobe is one transaction checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      exp_result_t w;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected", 0, 0);
      end else begin
        w = expected_results.pop_front();
        if (mantissa !== w.mant) report_mismatch("mantissa", mantissa, w.mant);
        if (exponent !== w.expo) report_mismatch("exponent", exponent, w.expo);
        if (status !== w.stat) report_mismatch("status", status, w.stat);
        if (range_error !== w.rerr) report_mismatch("range_error", range_error, w.rerr);
        if (w.stat != STATUS_NORMAL) clamp_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("timeout");
      $display("FAIL exp_rational_approx");
      $finish;
    end
  end

  initial begin
    logic [ARG_W-1:0] lows[4], highs[4];
    pred_low = longint'(LOW_LIMIT_RST);
    pred_high = longint'(HIGH_LIMIT_RST);
    lows = '{LOW_LIMIT_RST, 27'h400_0000, 27'd0, -27'sd655360};
    highs = '{ARG_W'(HIGH_LIMIT_RST), 27'h3FF_FFFF, 27'd0, 27'd655360};
    queue_arg(27'h400_0000, 0);
    queue_arg(27'h3FF_FFFF, 0);
    queue_arg(27'h7FF_FFFF, 0);
    queue_arg(27'd0, 0);
    queue_arg(27'd1, 1);
    queue_arg(LOW_LIMIT_RST, 0);
    queue_arg(LOW_LIMIT_RST + 27'd1, 0);
    queue_arg(LOW_LIMIT_RST - 27'd1, 0);
    queue_arg(ARG_W'(HIGH_LIMIT_RST), 0);
    queue_arg(HIGH_LIMIT_RST - 27'd1, 2);
    queue_arg(HIGH_LIMIT_RST + 27'd1, 0);
    queue_arg(27'd22713, 0);
    queue_arg(27'd22714, 0);
    queue_arg(-27'sd22714, 0);
    queue_arg(27'd45426, 0);
    queue_arg(-27'sd45426, 0);
    queue_arg(27'd65536, 0);
    queue_arg(-27'sd65536, 0);
    queue_arg(27'h155_5555, 0);
    queue_arg(27'h6AA_AAAA, 0);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        queue_cfg(REG_LOW_LIMIT, lows[ph % 4]);
        queue_cfg(REG_HIGH_LIMIT, highs[ph % 4]);
      end
      for (int i = 0; i < 320; i++) begin
        if (ph > 0) begin
          pred_low = longint'($signed(lows[ph % 4]));
          pred_high = longint'(highs[ph % 4][HIGH_W-1:0]);
        end
        queue_arg(rand_arg(), (i < 60) ? 0 : rand_gap());
      end
    end
    pred_low = longint'(LOW_LIMIT_RST);
    pred_high = longint'(HIGH_LIMIT_RST);
    // Every item above is built before any runs, so reset the predictor's limits.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_results.size() == 0);
    repeat (160) @(posedge clk);
    $display("Ran %0d arguments, %0d results, %0d clamped, %0d limit writes.",
             args_sent, results_seen, clamp_count, cfg_writes);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS exp_rational_approx");
    end else begin
      $display("FAIL exp_rational_approx");
    end
    $finish;
  end
endmodule
